// ===== sv/dqpc_pkg.sv =====
package dqpc_pkg;

  // Ring size; ring arithmetic wraps on the address bits, so DEPTH is a power of two
  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;

  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Channel field widths
  localparam int OP_BITS       = 2;
  localparam int IN_WORD_BITS  = 32;
  localparam int LEN_BITS      = 9;
  localparam int OUT_WORD_BITS = 32;
  localparam int STAT_BITS     = 2;
  localparam int OCC_BITS      = 9;

  // Width for the room check: count plus requested length
  localparam int SUM_BITS = ((CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS) + 1;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT  = 2'd0,
    OP_PUSH_BACK   = 2'd1,
    OP_POP_FRONT   = 2'd2,
    OP_COPY_PREFIX = 2'd3
  } op_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_TOO_FEW = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Controller to word store
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
  } mem_req_t;

  // Controller to result register
  typedef struct packed {
    logic                     valid;
    logic [OUT_WORD_BITS-1:0] popped_word;
    status_t                  status;
    logic [OCC_BITS-1:0]      occupancy;
  } res_t;

endpackage

// ===== sv/dqpc_if.sv =====
interface dqpc_in_if;
  logic                              valid;
  logic                              ready;
  logic [dqpc_pkg::OP_BITS-1:0]      operation;
  logic [dqpc_pkg::IN_WORD_BITS-1:0] data_word;
  logic [dqpc_pkg::LEN_BITS-1:0]     prefix_len;

  modport source (output valid, operation, data_word, prefix_len, input ready);
  modport sink   (input valid, operation, data_word, prefix_len, output ready);
endinterface

interface dqpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [dqpc_pkg::OUT_WORD_BITS-1:0] popped_word;
  logic [dqpc_pkg::STAT_BITS-1:0]     status;
  logic [dqpc_pkg::OCC_BITS-1:0]      occupancy;

  modport source (output valid, popped_word, status, occupancy, input ready);
  modport sink   (input valid, popped_word, status, occupancy, output ready);
endinterface

// ===== sv/dqpc_store.sv =====
module dqpc_store (
  input  logic                               clk,
  input  dqpc_pkg::mem_req_t                 req,
  output logic [dqpc_pkg::WORD_BITS-1:0]     rd_data
);

  logic [dqpc_pkg::WORD_BITS-1:0] mem [dqpc_pkg::DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== sv/dqpc_ctrl.sv =====
module dqpc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  dqpc_in_if.sink                        in_ch,
  input  logic                           out_free,
  input  logic [dqpc_pkg::WORD_BITS-1:0] rd_data,
  output dqpc_pkg::mem_req_t             mem_req,
  output dqpc_pkg::res_t                 res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_COPY = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dqpc_pkg::ADDR_BITS-1:0]  front_r, front_nxt;
  logic [dqpc_pkg::CNT_BITS-1:0]   count_r, count_nxt;
  logic [dqpc_pkg::ADDR_BITS-1:0]  src_r, src_nxt;
  logic [dqpc_pkg::CNT_BITS-1:0]   k_r, k_nxt;
  logic [dqpc_pkg::CNT_BITS-1:0]   rd_i_r, rd_i_nxt;
  logic [dqpc_pkg::CNT_BITS-1:0]   wr_i_r, wr_i_nxt;
  logic                            rd_pend_r, rd_pend_nxt;

  logic                            accept;
  logic                            is_full;
  logic [dqpc_pkg::SUM_BITS-1:0]   cnt_ext;
  logic [dqpc_pkg::SUM_BITS-1:0]   len_ext;
  logic [dqpc_pkg::CNT_BITS-1:0]   wr_i_inc;
  logic [dqpc_pkg::WORD_BITS-1:0]  in_word;

  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == dqpc_pkg::CNT_BITS'(dqpc_pkg::DEPTH));
  assign cnt_ext     = dqpc_pkg::SUM_BITS'(count_r);
  assign len_ext     = dqpc_pkg::SUM_BITS'(in_ch.prefix_len);
  assign wr_i_inc    = wr_i_r + 1'b1;
  assign in_word     = dqpc_pkg::WORD_BITS'(in_ch.data_word);

  // Next-state and store access
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    src_nxt     = src_r;
    k_nxt       = k_r;
    rd_i_nxt    = rd_i_r;
    wr_i_nxt    = wr_i_r;
    rd_pend_nxt = 1'b0;
    mem_req     = '0;
    res         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res.valid  = 1'b1;
          res.status = dqpc_pkg::ST_OK;
          unique case (dqpc_pkg::op_t'(in_ch.operation))
            dqpc_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                res.status = dqpc_pkg::ST_FULL;
              end else begin
                front_nxt       = front_r - 1'b1;
                count_nxt       = count_r + 1'b1;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = front_r - 1'b1;
                mem_req.wr_data = in_word;
              end
            end
            dqpc_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                res.status = dqpc_pkg::ST_FULL;
              end else begin
                count_nxt       = count_r + 1'b1;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = front_r + count_r[dqpc_pkg::ADDR_BITS-1:0];
                mem_req.wr_data = in_word;
              end
            end
            dqpc_pkg::OP_POP_FRONT: begin
              if (count_r == '0) begin
                res.status = dqpc_pkg::ST_EMPTY;
              end else begin
                // result goes out once the read data is back
                res.valid       = 1'b0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = front_r;
                front_nxt       = front_r + 1'b1;
                count_nxt       = count_r - 1'b1;
                state_nxt       = S_POP;
              end
            end
            default: begin
              // copy prefix: checks in priority order
              if (in_ch.prefix_len == '0) begin
                res.status = dqpc_pkg::ST_OK;
              end else if (cnt_ext < len_ext) begin
                res.status = dqpc_pkg::ST_TOO_FEW;
              end else if ((cnt_ext + len_ext) >
                           dqpc_pkg::SUM_BITS'(dqpc_pkg::DEPTH)) begin
                res.status = dqpc_pkg::ST_FULL;
              end else begin
                res.valid = 1'b0;
                src_nxt   = front_r;
                k_nxt     = dqpc_pkg::CNT_BITS'(in_ch.prefix_len);
                front_nxt = front_r - dqpc_pkg::ADDR_BITS'(in_ch.prefix_len);
                count_nxt = dqpc_pkg::CNT_BITS'(cnt_ext + len_ext);
                rd_i_nxt  = '0;
                wr_i_nxt  = '0;
                state_nxt = S_COPY;
              end
            end
          endcase
          res.occupancy = dqpc_pkg::OCC_BITS'(count_nxt);
        end
      end

      S_POP: begin
        res.valid       = 1'b1;
        res.status      = dqpc_pkg::ST_OK;
        res.popped_word = dqpc_pkg::OUT_WORD_BITS'(rd_data);
        res.occupancy   = dqpc_pkg::OCC_BITS'(count_r);
        state_nxt       = S_IDLE;
      end

      S_COPY: begin
        // read source word i while writing word i-1; regions never overlap
        if (rd_i_r != k_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = src_r + rd_i_r[dqpc_pkg::ADDR_BITS-1:0];
          rd_i_nxt        = rd_i_r + 1'b1;
          rd_pend_nxt     = 1'b1;
        end
        if (rd_pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = front_r + wr_i_r[dqpc_pkg::ADDR_BITS-1:0];
          mem_req.wr_data = rd_data;
          wr_i_nxt        = wr_i_inc;
          if (wr_i_inc == k_r) begin
            res.valid     = 1'b1;
            res.status    = dqpc_pkg::ST_OK;
            res.occupancy = dqpc_pkg::OCC_BITS'(count_r);
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Copy bookkeeping
  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    k_r    <= k_nxt;
    rd_i_r <= rd_i_nxt;
    wr_i_r <= wr_i_nxt;
  end

endmodule

// ===== sv/deque_with_prefix_copy.sv =====
// Bounded double-ended queue of data words held in a ring memory with one write
// and one registered read port. Each request yields one result with a status and
// the occupancy after the operation. A push, a failed request or a zero-length
// copy completes in the idle state; a pop passes through the pop state, as the
// word comes out of the memory's registered read; a prefix copy of k words runs
// in the copy state, one memory read and one write per cycle. The next request
// is taken when idle and the result register is free or being drained in the
// same cycle. There is no clearing pass after reset; only held entries are read.
module deque_with_prefix_copy (
  input  logic        clk,
  input  logic        rst_n,
  dqpc_in_if.sink     in_ch,
  dqpc_out_if.source  out_ch
);

  dqpc_pkg::mem_req_t              mem_req;
  dqpc_pkg::res_t                  res;
  logic [dqpc_pkg::WORD_BITS-1:0]  rd_data;
  logic                            out_free;

  logic                               out_valid_r;
  logic [dqpc_pkg::OUT_WORD_BITS-1:0] out_word_r;
  logic [dqpc_pkg::STAT_BITS-1:0]     out_status_r;
  logic [dqpc_pkg::OCC_BITS-1:0]      out_occ_r;

  assign out_free = !out_valid_r || out_ch.ready;

  dqpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .rd_data  (rd_data),
    .mem_req  (mem_req),
    .res      (res)
  );

  dqpc_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_word_r   <= res.popped_word;
      out_status_r <= res.status;
      out_occ_r    <= res.occupancy;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.popped_word = out_word_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.occupancy   = out_occ_r;

endmodule

// ===== sv/dqpc_checker.sv =====
module dqpc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [dqpc_pkg::OUT_WORD_BITS-1:0] out_popped_word,
  input logic [dqpc_pkg::STAT_BITS-1:0]     out_status,
  input logic [dqpc_pkg::OCC_BITS-1:0]      out_occupancy
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_word) &&
    $stable(out_status) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // Occupancy stays within the ring
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= dqpc_pkg::OCC_BITS'(dqpc_pkg::DEPTH))
    else $error("occupancy above depth");

  // Empty status only with nothing held and no word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dqpc_pkg::ST_EMPTY |->
    out_occupancy == '0 && out_popped_word == '0)
    else $error("empty result with words held");

  // A full result cannot report an empty queue
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dqpc_pkg::ST_FULL |-> out_occupancy != '0)
    else $error("full result with empty queue");

endmodule

bind deque_with_prefix_copy dqpc_checker u_dqpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_popped_word (out_ch.popped_word),
  .out_status      (out_ch.status),
  .out_occupancy   (out_ch.occupancy)
);
